// File: sv/tgap_pkg.sv
// ----------------------------------------------------------------------------
// tgap_pkg
// shared types and constants of the uncompressed true-color tga byte parser
// ----------------------------------------------------------------------------
package tgap_pkg;

  // header layout
  localparam int unsigned HDR_LEN     = 18;
  localparam int unsigned HDR_IDX_W   = $clog2(HDR_LEN);
  localparam int unsigned HDR_CMAP    = 1;
  localparam int unsigned HDR_ITYPE   = 2;
  localparam int unsigned HDR_W_LO    = 12;
  localparam int unsigned HDR_W_HI    = 13;
  localparam int unsigned HDR_H_LO    = 14;
  localparam int unsigned HDR_H_HI    = 15;
  localparam int unsigned HDR_BITS    = 16;

  // accepted format codes
  localparam logic [7:0] CMAP_NONE      = 8'd0;
  localparam logic [7:0] ITYPE_TRUECOL  = 8'd2;
  localparam logic [7:0] BITS_24        = 8'd24;
  localparam logic [7:0] BITS_32        = 8'd32;
  localparam logic [7:0] ALPHA_OPAQUE   = 8'hFF;

  // a dimension is 16 bits, only values up to 32767 give pixels
  localparam int unsigned DIM_W       = 16;
  localparam int unsigned DIM_USE_W   = DIM_W - 1;
  localparam int unsigned PIX_CNT_W   = 2 * DIM_USE_W;

  typedef enum logic [2:0] {
    KIND_HEADER = 3'd0,
    KIND_PIXEL  = 3'd1,
    KIND_SHORT  = 3'd2,
    KIND_UNSUP  = 3'd3,
    KIND_TRUNC  = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_PIXELS = 2'd1,
    PH_IDLE   = 2'd2
  } phase_e;

endpackage

// File: sv/tgap_if.sv
// ----------------------------------------------------------------------------
// tgap stream interfaces
// byte input channel and result output channel, valid/ready handshake
// ----------------------------------------------------------------------------
interface tgap_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_file;

  modport source (output valid, output data_byte, output end_of_file, input ready);
  modport sink   (input valid, input data_byte, input end_of_file, output ready);
endinterface

interface tgap_result_if;
  logic                  valid;
  logic                  ready;
  tgap_pkg::kind_e       kind;
  logic [15:0]           image_width;
  logic [15:0]           image_height;
  logic [31:0]           pixel_word;
  logic                  final_pixel;

  modport source (output valid, output kind, output image_width, output image_height,
                  output pixel_word, output final_pixel, input ready);
  modport sink   (input valid, input kind, input image_width, input image_height,
                  input pixel_word, input final_pixel, output ready);
endinterface

// File: sv/tga_truecolor_byte_parser.sv
// ----------------------------------------------------------------------------
// tga_truecolor_byte_parser
// byte-serial parser for uncompressed true-color tga files: checks the
// 18-byte header and turns the pixel data into 32-bit words
// ----------------------------------------------------------------------------
//
//  channel   | modport        | beat carries
//  ----------+----------------+----------------------------------------------
//  byte_i    | tgap_byte_if   | data_byte, end_of_file
//  result_o  | tgap_result_if | kind, image_width, image_height, pixel_word,
//            |                | final_pixel
//
//  one byte beat per cycle while byte_i.ready is high; its result (if any)
//  shows on result_o in the cycle after the beat, from the result register
//  byte_i.ready is high while the result register is empty or being drained
//  in the same cycle, so a stalled result_o holds off only the next byte
//  reset clears the phase and the byte counters; the parser then waits for
//  the first header byte
//
module tga_truecolor_byte_parser (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  tgap_byte_if.sink              byte_i,
  tgap_result_if.source          result_o
);

  localparam int unsigned IdxW = tgap_pkg::HDR_IDX_W;
  localparam int unsigned CntW = tgap_pkg::PIX_CNT_W;

  // control state
  tgap_pkg::phase_e phase_q, phase_d;
  logic [IdxW-1:0]  hdr_idx_q, hdr_idx_d;
  logic [1:0]       pos_q, pos_d;          // byte position inside the pixel

  // header fields kept for the check at the last header byte
  logic [7:0]       cmap_q, itype_q, bits_q;
  logic [7:0]       w_lo_q, w_hi_q, h_lo_q, h_hi_q;

  // pixel state: format and pixel count loaded when the header is taken
  logic             bpp4_q, bpp4_d;
  logic [CntW-1:0]  pix_left_q, pix_left_d;
  logic [7:0]       asm_q [3];

  // result register
  logic             out_valid_q, out_valid_d;
  tgap_pkg::kind_e  kind_q, kind_d;
  logic [15:0]      width_q, width_d;
  logic [15:0]      height_q, height_d;
  logic [31:0]      word_q, word_d;
  logic             final_q, final_d;
  logic             has_result;

  logic             in_ready;
  logic             accept;
  logic             eof;
  logic [7:0]       din;

  // header decode
  logic [15:0]      width;
  logic [15:0]      height;
  logic             hdr_last;
  logic             unsup;
  logic             empty_img;
  logic [CntW-1:0]  pix_count;

  // pixel decode
  logic             px_last_byte;
  logic             px_last;
  logic [31:0]      px_word;

  assign in_ready     = !out_valid_q || result_o.ready;
  assign byte_i.ready = in_ready;
  assign accept       = byte_i.valid && in_ready;
  assign eof          = byte_i.end_of_file;
  assign din          = byte_i.data_byte;

  assign width     = {w_hi_q, w_lo_q};
  assign height    = {h_hi_q, h_lo_q};
  assign hdr_last  = hdr_idx_q == IdxW'(tgap_pkg::HDR_LEN - 1);
  assign unsup     = (cmap_q != tgap_pkg::CMAP_NONE) || (itype_q != tgap_pkg::ITYPE_TRUECOL)
                     || ((bits_q != tgap_pkg::BITS_24) && (bits_q != tgap_pkg::BITS_32));
  // a dimension with its top bit set counts as negative and gives no pixels
  assign empty_img = width[tgap_pkg::DIM_W-1] || height[tgap_pkg::DIM_W-1]
                     || (width == '0) || (height == '0);
  assign pix_count = CntW'(width[tgap_pkg::DIM_USE_W-1:0])
                     * CntW'(height[tgap_pkg::DIM_USE_W-1:0]);

  assign px_last_byte = bpp4_q ? (pos_q == 2'd3) : (pos_q == 2'd2);
  assign px_last      = pix_left_q == CntW'(1);
  // missing alpha byte reads as opaque
  assign px_word      = bpp4_q ? {din, asm_q[2], asm_q[1], asm_q[0]}
                               : {tgap_pkg::ALPHA_OPAQUE, din, asm_q[1], asm_q[0]};

  // next state
  always_comb begin
    phase_d    = phase_q;
    hdr_idx_d  = hdr_idx_q;
    pos_d      = pos_q;
    bpp4_d     = bpp4_q;
    pix_left_d = pix_left_q;
    if (accept) begin
      unique case (phase_q)
        tgap_pkg::PH_HEADER: begin
          if (!hdr_last) begin
            hdr_idx_d = eof ? '0 : hdr_idx_q + IdxW'(1);
          end else begin
            hdr_idx_d = '0;
            pos_d     = '0;
            if (unsup || empty_img) begin
              phase_d = eof ? tgap_pkg::PH_HEADER : tgap_pkg::PH_IDLE;
            end else if (eof) begin
              phase_d = tgap_pkg::PH_HEADER;
            end else begin
              phase_d    = tgap_pkg::PH_PIXELS;
              bpp4_d     = bits_q == tgap_pkg::BITS_32;
              pix_left_d = pix_count;
            end
          end
        end
        tgap_pkg::PH_PIXELS: begin
          if (!px_last_byte) begin
            pos_d = pos_q + 2'd1;
            if (eof) begin
              phase_d = tgap_pkg::PH_HEADER;
              pos_d   = '0;
            end
          end else begin
            pos_d      = '0;
            pix_left_d = pix_left_q - CntW'(1);
            if (px_last) begin
              phase_d = eof ? tgap_pkg::PH_HEADER : tgap_pkg::PH_IDLE;
            end else if (eof) begin
              phase_d = tgap_pkg::PH_HEADER;
            end
          end
        end
        tgap_pkg::PH_IDLE: begin
          if (eof) begin
            phase_d = tgap_pkg::PH_HEADER;
          end
        end
        default: begin
          if (eof) begin
            phase_d = tgap_pkg::PH_HEADER;
          end
        end
      endcase
    end
  end

  // result of the current beat
  always_comb begin
    has_result = 1'b0;
    kind_d     = tgap_pkg::KIND_HEADER;
    width_d    = '0;
    height_d   = '0;
    word_d     = '0;
    final_d    = 1'b0;
    unique case (phase_q)
      tgap_pkg::PH_HEADER: begin
        if (!hdr_last) begin
          has_result = eof;
          kind_d     = tgap_pkg::KIND_SHORT;
        end else begin
          has_result = 1'b1;
          if (unsup) begin
            kind_d = tgap_pkg::KIND_UNSUP;
          end else if (empty_img) begin
            kind_d   = tgap_pkg::KIND_HEADER;
            width_d  = width;
            height_d = height;
            final_d  = 1'b1;
          end else if (eof) begin
            // header fills the whole file: no pixel data at all
            kind_d = tgap_pkg::KIND_TRUNC;
          end else begin
            kind_d   = tgap_pkg::KIND_HEADER;
            width_d  = width;
            height_d = height;
          end
        end
      end
      tgap_pkg::PH_PIXELS: begin
        if (!px_last_byte) begin
          has_result = eof;
          kind_d     = tgap_pkg::KIND_TRUNC;
        end else if (px_last) begin
          has_result = 1'b1;
          kind_d     = tgap_pkg::KIND_PIXEL;
          word_d     = px_word;
          final_d    = 1'b1;
        end else if (eof) begin
          // end of file on a pixel that is not the last one
          has_result = 1'b1;
          kind_d     = tgap_pkg::KIND_TRUNC;
        end else begin
          has_result = 1'b1;
          kind_d     = tgap_pkg::KIND_PIXEL;
          word_d     = px_word;
        end
      end
      tgap_pkg::PH_IDLE: begin
        has_result = 1'b0;
      end
      default: begin
        has_result = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = has_result;
    end else if (result_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= tgap_pkg::PH_HEADER;
      hdr_idx_q   <= '0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      hdr_idx_q   <= hdr_idx_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  // header byte capture
  always_ff @(posedge clk_i) begin
    if (accept && (phase_q == tgap_pkg::PH_HEADER)) begin
      case (hdr_idx_q)
        IdxW'(tgap_pkg::HDR_CMAP):  cmap_q  <= din;
        IdxW'(tgap_pkg::HDR_ITYPE): itype_q <= din;
        IdxW'(tgap_pkg::HDR_W_LO):  w_lo_q  <= din;
        IdxW'(tgap_pkg::HDR_W_HI):  w_hi_q  <= din;
        IdxW'(tgap_pkg::HDR_H_LO):  h_lo_q  <= din;
        IdxW'(tgap_pkg::HDR_H_HI):  h_hi_q  <= din;
        IdxW'(tgap_pkg::HDR_BITS):  bits_q  <= din;
        default: ;
      endcase
    end
  end

  // pixel assembly and counters
  always_ff @(posedge clk_i) begin
    bpp4_q     <= bpp4_d;
    pix_left_q <= pix_left_d;
    if (accept && (phase_q == tgap_pkg::PH_PIXELS) && !px_last_byte) begin
      case (pos_q)
        2'd0:    asm_q[0] <= din;
        2'd1:    asm_q[1] <= din;
        2'd2:    asm_q[2] <= din;
        default: ;
      endcase
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (accept && has_result) begin
      kind_q   <= kind_d;
      width_q  <= width_d;
      height_q <= height_d;
      word_q   <= word_d;
      final_q  <= final_d;
    end
  end

  assign result_o.valid        = out_valid_q;
  assign result_o.kind         = kind_q;
  assign result_o.image_width  = width_q;
  assign result_o.image_height = height_q;
  assign result_o.pixel_word   = word_q;
  assign result_o.final_pixel  = final_q;

`ifndef NO_ASSERTIONS
  // header counter only runs in the header phase
  a_idx_outside_hdr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q != tgap_pkg::PH_HEADER |-> hdr_idx_q == '0)
    else $error("header counter not cleared outside the header phase");

  // pixel phase always owes at least one pixel
  a_pix_owed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == tgap_pkg::PH_PIXELS |-> pix_left_q != '0)
    else $error("pixel phase with no pixel owed");

  // a byte in the idle phase produces no result
  a_idle_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (phase_q == tgap_pkg::PH_IDLE) |=> !out_valid_q)
    else $error("result produced from a trailing byte");

  // last byte of a file rearms the parser
  a_eof_rearm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && eof |=> (phase_q == tgap_pkg::PH_HEADER) && (hdr_idx_q == '0) && (pos_q == '0))
    else $error("end of file did not rearm the parser");
`endif

endmodule
